### hw/rtl/alcd_pkg.sv
package alcd_pkg;

    // Directory geometry
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;
    localparam int AGE_BITS = 8;

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Saturation point of an entry age
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // Fixed port widths
    localparam int IN_KEY_BITS  = 32;
    localparam int OUT_IDX_BITS = 4;
    localparam int EXT_IDX_BITS = (IDX_BITS > OUT_IDX_BITS) ? IDX_BITS : OUT_IDX_BITS;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic load;    // capture request, restart scan
        logic step;    // examine one entry
        logic commit;  // update directory, load result register
    } t_ctl_cmd;

    typedef struct packed {
        logic last;    // scan pointer on final entry
    } t_ctl_status;

endpackage

### hw/rtl/alcd_ctrl.sv
module alcd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  alcd_pkg::t_ctl_status i_status,
    output alcd_pkg::t_ctl_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hw/rtl/alcd_datapath.sv
module alcd_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  alcd_pkg::t_ctl_cmd                   i_cmd,
    output alcd_pkg::t_ctl_status                o_status,
    input  logic                                 i_op,
    input  logic [alcd_pkg::IN_KEY_BITS-1:0]     i_key,
    output logic                                 o_hit,
    output logic [alcd_pkg::OUT_IDX_BITS-1:0]    o_entry_index,
    output logic                                 o_evicted
);

    // Directory state
    logic [alcd_pkg::ENTRIES-1:0]  r_valid;
    logic [alcd_pkg::AGE_BITS-1:0] r_age  [alcd_pkg::ENTRIES];
    logic [alcd_pkg::KEY_BITS-1:0] r_keys [alcd_pkg::ENTRIES];

    // Request and scan state
    logic                          r_op;
    logic [alcd_pkg::KEY_BITS-1:0] r_key;
    logic [alcd_pkg::IDX_BITS-1:0] r_scan;
    logic [alcd_pkg::IDX_BITS-1:0] r_sel;
    logic                          r_found;  // lookup match, or empty slot on insert
    logic [alcd_pkg::AGE_BITS-1:0] r_best;

    logic                          cur_valid;
    logic [alcd_pkg::KEY_BITS-1:0] cur_key;
    logic [alcd_pkg::AGE_BITS-1:0] cur_age;
    logic                          do_touch;
    logic                          is_insert;
    logic [alcd_pkg::EXT_IDX_BITS-1:0] sel_ext;

    assign cur_valid = r_valid[r_scan];
    assign cur_key   = r_keys[r_scan];
    assign cur_age   = r_age[r_scan];
    assign is_insert = (r_op == alcd_pkg::OP_INSERT);
    assign do_touch  = is_insert || r_found;
    assign sel_ext   = alcd_pkg::EXT_IDX_BITS'(r_sel);

    assign o_status.last = (r_scan == alcd_pkg::IDX_BITS'(alcd_pkg::ENTRIES - 1));

    // Request capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= alcd_pkg::KEY_BITS'(i_key);
            r_scan  <= '0;
            r_sel   <= '0;
            r_found <= 1'b0;
            r_best  <= '0;
        end else if (i_cmd.step) begin
            r_scan <= r_scan + 1'b1;
            if (!is_insert) begin
                // last match wins
                if (cur_valid && (cur_key == r_key)) begin
                    r_sel   <= r_scan;
                    r_found <= 1'b1;
                end
            end else if (!r_found) begin
                if (!cur_valid) begin
                    r_sel   <= r_scan;
                    r_found <= 1'b1;
                end else if (cur_age > r_best) begin
                    r_best <= cur_age;
                    r_sel  <= r_scan;
                end
            end
        end
    end

    // Valid bits and ages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < alcd_pkg::ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_cmd.commit && do_touch) begin
            if (is_insert) begin
                r_valid[r_sel] <= 1'b1;
            end
            for (int i = 0; i < alcd_pkg::ENTRIES; i++) begin
                if (alcd_pkg::IDX_BITS'(i) == r_sel) begin
                    r_age[i] <= '0;
                end else if (r_valid[i] && (r_age[i] != alcd_pkg::AGE_MAX)) begin
                    r_age[i] <= r_age[i] + 1'b1;
                end
            end
        end
    end

    // Key store
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && is_insert) begin
            r_keys[r_sel] <= r_key;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit         <= !is_insert && r_found;
            o_entry_index <= do_touch ? sel_ext[alcd_pkg::OUT_IDX_BITS-1:0] : '0;
            o_evicted     <= is_insert && !r_found;
        end
    end

endmodule

### hw/rtl/aging_lru_cache_directory_top.sv
// Channel   Direction  Handshake               Payload
// request   in         i_in_valid/o_in_stall    i_op, i_key
// result    out        o_out_valid/i_out_stall  o_hit, o_entry_index, o_evicted
//
// Each request is accepted, then scanned by a pointer walking every entry (one
// key/age compare per cycle), then committed to update the directory.
// Reset (synchronous, active low) empties the directory and clears all ages at once.
// A result waits in the output register while stalled; the next request may be
// accepted and scanned meanwhile, and its update holds until the register is free.
module aging_lru_cache_directory_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic [alcd_pkg::IN_KEY_BITS-1:0]   i_key,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic [alcd_pkg::OUT_IDX_BITS-1:0]  o_entry_index,
    output logic                               o_evicted
);

    alcd_pkg::t_ctl_cmd    ctl_cmd;
    alcd_pkg::t_ctl_status ctl_status;

    // Sequencer: accept, scan, commit
    alcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (ctl_status),
        .o_cmd       (ctl_cmd)
    );

    // Entry storage, scan compare and age update
    alcd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctl_cmd),
        .o_status      (ctl_status),
        .i_op          (i_op),
        .i_key         (i_key),
        .o_hit         (o_hit),
        .o_entry_index (o_entry_index),
        .o_evicted     (o_evicted)
    );

    // A commit never overwrites a result that is still waiting.
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("commit while result register busy");

    // An accepted request blocks further transfers until committed.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted twice in a row");

    // A result is either a hit or an eviction, never both.
    a_hit_not_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported together");

    // Scan ends only on the final entry, then a commit is pending.
    a_scan_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl_cmd.step && ctl_status.last) |=> !ctl_cmd.step && o_in_stall)
        else $error("scan did not stop at final entry");

endmodule
